[rtl/sgpa_pkg.sv]
// Types, constants and step functions for the softened pair gravity pipeline.
`default_nettype none

package sgpa_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned NSQ       = 32;   // one root bit per stage
  localparam int unsigned NDIV      = 32;   // one quotient bit per stage
  localparam int unsigned DEN_W     = 65;
  localparam int unsigned DD_W      = 97;

  localparam logic [31:0] GRAV_RESET   = 32'd65536;
  localparam logic [31:0] CUTOFF_RESET = 32'd655360;
  localparam logic [15:0] SOFT_RESET   = 16'd19661;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_GRAV   = 2'd0,
    CFG_CUTOFF = 2'd1,
    CFG_SOFT   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [15:0]        body_a_id;
    logic [15:0]        body_b_id;
    logic signed [31:0] pos_x_a;
    logic signed [31:0] pos_y_a;
    logic signed [31:0] pos_x_b;
    logic signed [31:0] pos_y_b;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] accel_x_a;
    logic signed [31:0] accel_y_a;
    logic signed [31:0] accel_x_b;
    logic signed [31:0] accel_y_b;
    logic               applied;
  } out_word_t;

  // square root stage
  typedef struct packed {
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [63:0]      sarg;
    logic [DEN_W-1:0] den;
    logic [63:0]      gma;
    logic [63:0]      gmb;
    logic [31:0]      adxp;
    logic [31:0]      ady;
    logic             dx_neg;
    logic             dy_neg;
    logic             skip;
  } sq_t;

  // partial products of numerators and denominator
  typedef struct packed {
    logic [63:0]                 ddl;
    logic [64:0]                 ddh;
    logic [NUM_LANES-1:0][63:0]  pl;
    logic [NUM_LANES-1:0][63:0]  ph;
    logic [NUM_LANES-1:0]        neg;
    logic [NUM_LANES-1:0]        zero;
    logic                        skip;
  } mul_t;

  typedef struct packed {
    logic [DD_W-1:0]                 dd;
    logic [NUM_LANES-1:0][DD_W-1:0]  nhi;
    logic [NUM_LANES-1:0][31:0]      nlo;
    logic [NUM_LANES-1:0]            neg;
    logic [NUM_LANES-1:0]            zero;
    logic                            skip;
  } prep_t;

  // divider stage, all four lanes share the denominator
  typedef struct packed {
    logic [NUM_LANES-1:0][DD_W-1:0]  r;
    logic [NUM_LANES-1:0][31:0]      nlo;
    logic [NUM_LANES-1:0][31:0]      q;
    logic [DD_W-1:0]                 dd;
    logic [NUM_LANES-1:0]            ovf;
    logic [NUM_LANES-1:0]            neg;
    logic [NUM_LANES-1:0]            zero;
    logic                            skip;
  } div_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
  } sq_step_t;

  typedef struct packed {
    logic            qbit;
    logic [DD_W-1:0] r;
  } div_step_t;

  function automatic sq_step_t sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                         input logic [1:0] pair);
    logic [35:0] rs;
    logic [35:0] t;
    sq_step_t    res;
    rs = {rem, pair};
    t  = {2'b00, root, 2'b01};
    if (rs >= t) begin
      res.rem  = 34'(rs - t);
      res.root = {root[30:0], 1'b1};
    end else begin
      res.rem  = rs[33:0];
      res.root = {root[30:0], 1'b0};
    end
    return res;
  endfunction

  function automatic div_step_t div_step(input logic [DD_W-1:0] r, input logic b,
                                         input logic [DD_W-1:0] dd);
    logic [DD_W:0] r2;
    div_step_t     res;
    r2 = {r, b};
    if (r2 >= {1'b0, dd}) begin
      res.qbit = 1'b1;
      res.r    = DD_W'(r2 - {1'b0, dd});
    end else begin
      res.qbit = 1'b0;
      res.r    = r2[DD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/softened_gravity_pair_accel.sv]
// Top level: pipelined softened pairwise gravity, one body pair per cycle unless stalled.
`default_nettype none

// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+-------------------------------
// in      | in        | in_valid / in_stall       | in_word  (ids, positions, masses)
// out     | out       | out_valid / out_stall     | out_word (four accels, applied)
// cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Throughput one pair per cycle unless out_stall holds it. Stages: 4 front
// (difference, magnitude, squares and G*m, distance sum and cutoff), 32 root,
// 3 of wide products, 32 divider stages and the output register.
// Reset (rst, synchronous) clears the valid bits and loads the default registers.
// out_stall with a word waiting freezes the whole pipe; in_stall follows it, so
// nothing is dropped or repeated.

module softened_gravity_pair_accel #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sgpa_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sgpa_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned EPS_CALC = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic [31:0] EPS_RAW  = (EPS_CALC == 0) ? 32'd1 : 32'(EPS_CALC);
  localparam logic [63:0] EPS_SQ   = 64'(EPS_RAW) * 64'(EPS_RAW);
  localparam int unsigned NW       = 96 + FRAC_BITS;   // numerator width after scaling

  // ---------------------------------------------------------------- config
  logic [31:0] grav;
  logic [31:0] cutoff;
  logic [15:0] soft_len;
  logic [63:0] c2;      // cutoff squared
  logic [31:0] soft2;   // softening squared

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav     <= sgpa_pkg::GRAV_RESET;
      cutoff   <= sgpa_pkg::CUTOFF_RESET;
      soft_len <= sgpa_pkg::SOFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgpa_pkg::CFG_GRAV:   grav     <= cfg_data;
        sgpa_pkg::CFG_CUTOFF: cutoff   <= cfg_data;
        sgpa_pkg::CFG_SOFT:   soft_len <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // squares of the registers, refreshed every cycle
  always_ff @(posedge clk) begin
    c2    <= 64'(cutoff) * 64'(cutoff);
    soft2 <= 32'(soft_len) * 32'(soft_len);
  end

  // ---------------------------------------------------------------- flow
  // The pipe moves whenever the output register is free or being taken.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic                  s1_v, s2_v, s3_v, s4_v, mul_v, prep_v, dvi_v;
  logic [sgpa_pkg::NSQ-1:0]  sq_v;
  logic [sgpa_pkg::NDIV-1:0] dv_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      sq_v      <= '0;
      mul_v     <= 1'b0;
      prep_v    <= 1'b0;
      dvi_v     <= 1'b0;
      dv_v      <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      sq_v      <= {sq_v[sgpa_pkg::NSQ-2:0], s4_v};
      mul_v     <= sq_v[sgpa_pkg::NSQ-1];
      prep_v    <= mul_v;
      dvi_v     <= prep_v;
      dv_v      <= {dv_v[sgpa_pkg::NDIV-2:0], dvi_v};
      out_valid <= dv_v[sgpa_pkg::NDIV-1];
    end
  end

  // ---------------------------------------------------------------- front end
  // s1: exact 33-bit differences b - a
  logic [32:0] s1_dx, s1_dy;
  logic        s1_same;
  logic [31:0] s1_ma, s1_mb;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= {in_word.pos_x_b[31], in_word.pos_x_b} - {in_word.pos_x_a[31], in_word.pos_x_a};
      s1_dy   <= {in_word.pos_y_b[31], in_word.pos_y_b} - {in_word.pos_y_a[31], in_word.pos_y_a};
      s1_same <= (in_word.body_a_id == in_word.body_b_id);
      s1_ma   <= in_word.mass_a;
      s1_mb   <= in_word.mass_b;
    end
  end

  // s2: magnitudes and signs
  logic [31:0] s2_adx, s2_ady;
  logic        s2_dx_neg, s2_dy_neg, s2_same;
  logic [31:0] s2_ma, s2_mb;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_adx    <= s1_dx[32] ? 32'(~s1_dx + 33'd1) : s1_dx[31:0];
      s2_ady    <= s1_dy[32] ? 32'(~s1_dy + 33'd1) : s1_dy[31:0];
      s2_dx_neg <= s1_dx[32];
      s2_dy_neg <= s1_dy[32];
      s2_same   <= s1_same;
      s2_ma     <= s1_ma;
      s2_mb     <= s1_mb;
    end
  end

  // s3: squares and G*m; a zero dx is replaced by the epsilon
  logic [63:0] s3_adx2, s3_ady2, s3_gma, s3_gmb;
  logic [31:0] s3_adxp, s3_ady;
  logic        s3_adx_zero, s3_dx_neg, s3_dy_neg, s3_same;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_adx2     <= 64'(s2_adx) * 64'(s2_adx);
      s3_ady2     <= 64'(s2_ady) * 64'(s2_ady);
      s3_gma      <= 64'(grav) * 64'(s2_mb);   // pull on a uses m_b
      s3_gmb      <= 64'(grav) * 64'(s2_ma);
      s3_adx_zero <= (s2_adx == 32'd0);
      s3_adxp     <= (s2_adx == 32'd0) ? EPS_RAW : s2_adx;
      s3_ady      <= s2_ady;
      s3_dx_neg   <= s2_dx_neg;
      s3_dy_neg   <= s2_dy_neg;
      s3_same     <= s2_same;
    end
  end

  // s4: distance squared, cutoff test, softened denominator, root argument
  sgpa_pkg::sq_t s4;
  logic [64:0]   s3_d2;

  assign s3_d2 = 65'(s3_adx2) + 65'(s3_ady2);

  always_ff @(posedge clk) begin
    if (en) begin
      s4.rem    <= '0;
      s4.root   <= '0;
      s4.sarg   <= (s3_adx_zero ? EPS_SQ : s3_adx2) + s3_ady2;
      s4.den    <= 65'(s3_adx2) + 65'(s3_ady2) + 65'(soft2);
      s4.gma    <= s3_gma;
      s4.gmb    <= s3_gmb;
      s4.adxp   <= s3_adxp;
      s4.ady    <= s3_ady;
      s4.dx_neg <= s3_dx_neg;
      s4.dy_neg <= s3_dy_neg;
      s4.skip   <= s3_same || (s3_d2 > {1'b0, c2});
    end
  end

  // ---------------------------------------------------------------- square root
  sgpa_pkg::sq_t sq [sgpa_pkg::NSQ];

  for (genvar k = 0; k < sgpa_pkg::NSQ; k++) begin : g_sq
    sgpa_pkg::sq_t      prev, nxt;
    sgpa_pkg::sq_step_t st;

    if (k == 0) begin : g_first
      assign prev = s4;
    end else begin : g_next
      assign prev = sq[k-1];
    end

    always_comb begin
      st       = sgpa_pkg::sqrt_step(prev.rem, prev.root,
                                     prev.sarg[2*(sgpa_pkg::NSQ-1-k) +: 2]);
      nxt      = prev;
      nxt.rem  = st.rem;
      nxt.root = st.root;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------- products
  sgpa_pkg::sq_t sqo;
  logic [63:0]   lane_gm [sgpa_pkg::NUM_LANES];
  logic [31:0]   lane_al [sgpa_pkg::NUM_LANES];
  sgpa_pkg::mul_t mul;

  assign sqo = sq[sgpa_pkg::NSQ-1];

  // lanes: x of a, y of a, x of b, y of b
  always_comb begin
    lane_gm[0] = sqo.gma;  lane_al[0] = sqo.adxp;
    lane_gm[1] = sqo.gma;  lane_al[1] = sqo.ady;
    lane_gm[2] = sqo.gmb;  lane_al[2] = sqo.adxp;
    lane_gm[3] = sqo.gmb;  lane_al[3] = sqo.ady;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul.ddl  <= 64'(sqo.den[31:0]) * 64'(sqo.root);
      mul.ddh  <= 65'(sqo.den[64:32]) * 65'(sqo.root);
      for (int l = 0; l < sgpa_pkg::NUM_LANES; l++) begin
        mul.pl[l] <= 64'(lane_gm[l][31:0]) * 64'(lane_al[l]);
        mul.ph[l] <= 64'(lane_gm[l][63:32]) * 64'(lane_al[l]);
      end
      mul.neg  <= {~sqo.dy_neg, ~sqo.dx_neg, sqo.dy_neg, sqo.dx_neg};
      mul.zero <= {(sqo.ady == 32'd0), 1'b0, (sqo.ady == 32'd0), 1'b0};
      mul.skip <= sqo.skip;
    end
  end

  // prep: sum partial products, scale numerator, split for the divider
  logic [95:0]    pfull [sgpa_pkg::NUM_LANES];
  logic [NW-1:0]  nfull [sgpa_pkg::NUM_LANES];
  sgpa_pkg::prep_t prep;

  always_comb begin
    for (int l = 0; l < sgpa_pkg::NUM_LANES; l++) begin
      pfull[l] = 96'(mul.pl[l]) + {mul.ph[l], 32'b0};
      nfull[l] = {pfull[l], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep.dd <= 97'(mul.ddl) + {mul.ddh, 32'b0};
      for (int l = 0; l < sgpa_pkg::NUM_LANES; l++) begin
        prep.nhi[l]  <= 97'(nfull[l][NW-1:32]);
        prep.nlo[l]  <= nfull[l][31:0];
        prep.zero[l] <= mul.zero[l] || (pfull[l] == 96'd0);
      end
      prep.neg  <= mul.neg;
      prep.skip <= mul.skip;
    end
  end

  // dvi: quotient of 2^32 or more saturates; otherwise 32 bits follow
  sgpa_pkg::div_t dvi;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < sgpa_pkg::NUM_LANES; l++) begin
        dvi.r[l]   <= prep.nhi[l];
        dvi.ovf[l] <= (prep.nhi[l] >= prep.dd);
      end
      dvi.nlo  <= prep.nlo;
      dvi.q    <= '0;
      dvi.dd   <= prep.dd;
      dvi.neg  <= prep.neg;
      dvi.zero <= prep.zero;
      dvi.skip <= prep.skip;
    end
  end

  // ---------------------------------------------------------------- divider
  sgpa_pkg::div_t dv [sgpa_pkg::NDIV];

  for (genvar k = 0; k < sgpa_pkg::NDIV; k++) begin : g_div
    sgpa_pkg::div_t      prev, nxt;
    sgpa_pkg::div_step_t st [sgpa_pkg::NUM_LANES];

    if (k == 0) begin : g_first
      assign prev = dvi;
    end else begin : g_next
      assign prev = dv[k-1];
    end

    always_comb begin
      nxt = prev;
      for (int l = 0; l < sgpa_pkg::NUM_LANES; l++) begin
        st[l]     = sgpa_pkg::div_step(prev.r[l], prev.nlo[l][sgpa_pkg::NDIV-1-k], prev.dd);
        nxt.r[l]  = st[l].r;
        nxt.q[l]  = {prev.q[l][30:0], st[l].qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------- output
  sgpa_pkg::div_t dvo;
  logic [31:0]    lim  [sgpa_pkg::NUM_LANES];
  logic [31:0]    mag  [sgpa_pkg::NUM_LANES];
  logic [31:0]    lane [sgpa_pkg::NUM_LANES];

  assign dvo = dv[sgpa_pkg::NDIV-1];

  always_comb begin
    for (int l = 0; l < sgpa_pkg::NUM_LANES; l++) begin
      lim[l] = dvo.neg[l] ? sgpa_pkg::SAT_NEG : sgpa_pkg::SAT_POS;
      if (dvo.ovf[l] || (dvo.q[l] > lim[l])) begin
        mag[l] = lim[l];
      end else begin
        mag[l] = dvo.q[l];
      end
      if (dvo.skip || dvo.zero[l]) begin
        lane[l] = '0;
      end else if (dvo.neg[l]) begin
        lane[l] = 32'(~mag[l] + 32'd1);
      end else begin
        lane[l] = mag[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.accel_x_a <= lane[0];
      out_word.accel_y_a <= lane[1];
      out_word.accel_x_b <= lane[2];
      out_word.accel_y_b <= lane[3];
      out_word.applied   <= !dvo.skip;
    end
  end

  // ---------------------------------------------------------------- checks
  a_skip_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.applied |->
      out_word.accel_x_a == 0 && out_word.accel_y_a == 0 &&
      out_word.accel_x_b == 0 && out_word.accel_y_b == 0)
    else $error("skipped pair carries nonzero acceleration");

  a_x_opposed : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.applied && out_word.accel_x_a[31] |-> !out_word.accel_x_b[31])
    else $error("x accelerations of a pair point the same way");

  a_y_opposed : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.applied && out_word.accel_y_a[31] |-> !out_word.accel_y_b[31])
    else $error("y accelerations of a pair point the same way");

  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(dv_v[sgpa_pkg::NDIV-1]))
    else $error("result appeared without a word leaving the divider");

  a_frozen : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dv_v) && $stable(sq_v))
    else $error("pipeline moved while the output was held");

endmodule

`default_nettype wire

[sim/sgpa_checker.sv]
// Checker for the pair gravity block: predicts each output word and compares it.
`timescale 1ns / 1ps

module sgpa_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sgpa_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sgpa_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam logic [127:0] EPS_Q = 128'd66;  // 0.001 in Q16.16, rounded

  logic [31:0]         grav_q;
  logic [31:0]         cutoff_q;
  logic [15:0]         soft_q;
  sgpa_pkg::out_word_t accel_fifo[$];

  function automatic logic [127:0] root_floor(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one signed, saturated component: sign * floor(gm*along*2^16 / dd)
  function automatic logic [31:0] accel_part(input logic [127:0] gm, input logic [127:0] along,
                                             input logic [127:0] dd, input int sgn);
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] lim;
    logic [127:0] mag;
    if (sgn == 0) return 32'd0;
    num = (gm * along) << 16;
    if (dd == 0) quo = (num == 0) ? '0 : '1;
    else quo = num / dd;
    lim = (sgn < 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
    mag = (quo > lim) ? lim : quo;
    return (sgn < 0) ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic sgpa_pkg::out_word_t pair_accel(input sgpa_pkg::in_word_t w);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [127:0] adx, ady, d2, den, adxp, dp, dd, gma, gmb;
    int sx, sy;
    sgpa_pkg::out_word_t r;
    r  = '0;
    dx = 64'(w.pos_x_b) - 64'(w.pos_x_a);
    dy = 64'(w.pos_y_b) - 64'(w.pos_y_a);
    adx = (dx < 0) ? 128'(-dx) : 128'(dx);
    ady = (dy < 0) ? 128'(-dy) : 128'(dy);
    d2  = adx * adx + ady * ady;
    if (d2 > 128'(cutoff_q) * 128'(cutoff_q)) return r;
    if (w.body_a_id == w.body_b_id) return r;
    den = d2 + 128'(soft_q) * 128'(soft_q);
    if (adx == 0) begin
      adxp = EPS_Q;
      sx   = 1;
    end else begin
      adxp = adx;
      sx   = (dx < 0) ? -1 : 1;
    end
    sy  = (ady == 0) ? 0 : ((dy < 0) ? -1 : 1);
    dp  = root_floor(adxp * adxp + ady * ady);
    dd  = den * dp;
    gma = 128'(grav_q) * 128'(w.mass_b);
    gmb = 128'(grav_q) * 128'(w.mass_a);
    r.accel_x_a = accel_part(gma, adxp, dd, sx);
    r.accel_y_a = accel_part(gma, ady, dd, sy);
    r.accel_x_b = accel_part(gmb, adxp, dd, -sx);
    r.accel_y_b = accel_part(gmb, ady, dd, -sy);
    r.applied   = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    sgpa_pkg::out_word_t want;
    if (rst) begin
      grav_q   <= sgpa_pkg::GRAV_RESET;
      cutoff_q <= sgpa_pkg::CUTOFF_RESET;
      soft_q   <= sgpa_pkg::SOFT_RESET;
      errors   <= 0;
      pending  <= 0;
      accel_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sgpa_pkg::CFG_GRAV:   grav_q   <= cfg_data;
          sgpa_pkg::CFG_CUTOFF: cutoff_q <= cfg_data;
          sgpa_pkg::CFG_SOFT:   soft_q   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) accel_fifo.push_back(pair_accel(in_word));
      if (out_valid && !out_stall) begin
        if (accel_fifo.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          errors <= errors + 1;
        end else begin
          want = accel_fifo.pop_front();
          if (want.accel_x_a !== out_word.accel_x_a || want.accel_y_a !== out_word.accel_y_a ||
              want.accel_x_b !== out_word.accel_x_b || want.accel_y_b !== out_word.accel_y_b ||
              want.applied !== out_word.applied) begin
            $display("%0t: mismatch exp ax_a=%h ay_a=%h ax_b=%h ay_b=%h app=%b",
                     $time, want.accel_x_a, want.accel_y_a, want.accel_x_b,
                     want.accel_y_b, want.applied);
            $display("%0t:          got ax_a=%h ay_a=%h ax_b=%h ay_b=%h app=%b",
                     $time, out_word.accel_x_a, out_word.accel_y_a, out_word.accel_x_b,
                     out_word.accel_y_b, out_word.applied);
            errors <= errors + 1;
          end
        end
      end
      pending <= accel_fifo.size();
    end
  end

endmodule

[sim/softened_gravity_pair_accel_test.sv]
// Testbench top: stimulus, idling, configuration phases and the verdict.
`timescale 1ns / 1ps

module softened_gravity_pair_accel_test;

  localparam logic [1:0] CFG_NONE = 2'd3;  // unmapped index, block must ignore it
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;        // pipe is 72 deep

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sgpa_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sgpa_pkg::out_word_t out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = sgpa_pkg::CFG_GRAV;
  logic [31:0]         cfg_data = '0;
  int                  errors;
  int                  pending;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  cycles = 0;
  logic [31:0]         cut_now = sgpa_pkg::CUTOFF_RESET;   // steers the random offsets

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  softened_gravity_pair_accel u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sgpa_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // receiver backpressure
  always @(posedge clk) out_stall <= !rst && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stall is stable at the falling edge, so sample the handshake there
  task automatic send_pair(input sgpa_pkg::in_word_t w);
    logic taken;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // pending is registered, so wait for a clock edge after the last word went in
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == sgpa_pkg::CFG_CUTOFF) cut_now = val;
  endtask

  function automatic sgpa_pkg::in_word_t make_pair(input logic [15:0] ida,
                                                   input logic [15:0] idb,
                                                   input logic [31:0] xa, input logic [31:0] ya,
                                                   input logic [31:0] xb, input logic [31:0] yb,
                                                   input logic [31:0] ma, input logic [31:0] mb);
    sgpa_pkg::in_word_t w;
    w.body_a_id = ida; w.body_b_id = idb;
    w.pos_x_a = xa; w.pos_y_a = ya; w.pos_x_b = xb; w.pos_y_b = yb;
    w.mass_a = ma; w.mass_b = mb;
    return w;
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // offset inside roughly 0.7 of the cutoff so most pairs interact
  function automatic logic [31:0] rand_offset();
    logic [31:0] span;
    logic [31:0] off;
    span = (cut_now > 32'h8000_0000) ? 32'h5A00_0000 : (cut_now / 10) * 7;
    case ($urandom_range(9))
      0: off = 32'd0;
      1: off = $urandom_range(3);
      default: off = $urandom_range(span);
    endcase
    return $urandom_range(1) ? off : -off;
  endfunction

  function automatic sgpa_pkg::in_word_t rand_pair();
    sgpa_pkg::in_word_t w;
    logic [15:0] id;
    id = 16'($urandom);
    w.body_a_id = id;
    w.body_b_id = ($urandom_range(9) == 0) ? id : 16'($urandom);
    w.pos_x_a = $urandom;
    w.pos_y_a = $urandom;
    if ($urandom_range(9) < 8) begin
      w.pos_x_b = w.pos_x_a + rand_offset();
      w.pos_y_b = w.pos_y_a + rand_offset();
    end else begin
      w.pos_x_b = $urandom;   // mostly out of range
      w.pos_y_b = $urandom;
    end
    w.mass_a = rand_mass();
    w.mass_b = rand_mass();
    return w;
  endfunction

  // coincident bodies and axis-aligned pairs, run in every setting
  task automatic axis_pairs();
    send_pair(make_pair(16'd1, 16'd2, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                        32'h0002_0000, 32'h0001_0000, 32'h0003_0000));
    send_pair(make_pair(16'd3, 16'd4, 32'h0001_0000, 32'd0, 32'h0001_0000,
                        32'hFFFF_0000, 32'h0005_0000, 32'h0001_0000));
    send_pair(make_pair(16'd5, 16'd6, 32'hFFFE_0000, 32'd7, 32'h0000_8000,
                        32'd7, 32'h0002_0000, 32'h0004_0000));
    send_pair(make_pair(16'd7, 16'd8, 32'd0, 32'd0, 32'd1, 32'd0,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  typedef struct {
    logic [31:0] grav;
    logic [31:0] cutoff;
    logic [15:0] soft_len;
  } reg_set_t;

  reg_set_t settings[6];

  initial begin
    int phase;
    int n;
    settings[0] = '{sgpa_pkg::GRAV_RESET, sgpa_pkg::CUTOFF_RESET, sgpa_pkg::SOFT_RESET};
    settings[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0};
    settings[2] = '{32'd0, 32'h0010_0000, 16'hFFFF};
    settings[3] = '{32'h0064_0000, 32'h0032_0000, 16'd1};
    settings[4] = '{32'($urandom), 32'($urandom), 16'($urandom)};
    settings[5] = '{32'h0000_0100, 32'd0, 16'h4CCD};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs under reset values
    send_pair(make_pair(16'd9, 16'd9, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000));                       // same ids
    send_pair(make_pair(16'd0, 16'hFFFF, 32'd0, 32'd0, 32'h000B_0000, 32'd0,
                        32'h0001_0000, 32'h0001_0000));                       // past cutoff
    send_pair(make_pair(16'd0, 16'hFFFF, 32'd0, 32'd0, 32'h000A_0000, 32'd0,
                        32'h0001_0000, 32'h0001_0000));                       // on cutoff
    send_pair(make_pair(16'd1, 16'd2, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));        // extremes
    send_pair(make_pair(16'd1, 16'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFF0,
                        32'h8000_0005, 32'hFFFF_FFFF, 32'hFFFF_FFFF));        // saturation
    send_pair(make_pair(16'd1, 16'd2, 32'd0, 32'd0, 32'h0003_0000, 32'h0004_0000,
                        32'd0, 32'd0));                                       // both massless
    send_pair(make_pair(16'd1, 16'd2, 32'd0, 32'd0, 32'hFFFD_0000, 32'hFFFC_0000,
                        32'd0, 32'h0002_0000));                               // a massless
    send_pair(make_pair(16'd1, 16'd2, 32'd0, 32'd0, 32'h0003_0000, 32'hFFFC_0000,
                        32'h0002_0000, 32'd0));                               // b massless
    send_pair(make_pair(16'hFFFF, 16'd0, 32'h1234_5678, 32'hEDCB_A987, 32'h1234_5678,
                        32'hEDCB_A987, 32'h0001_0000, 32'h0001_0000));        // coincident
    axis_pairs();

    for (phase = 0; phase < 6; phase++) begin
      drain();
      if (phase > 0) begin
        write_reg(sgpa_pkg::CFG_GRAV, settings[phase].grav);
        write_reg(sgpa_pkg::CFG_CUTOFF, settings[phase].cutoff);
        write_reg(sgpa_pkg::CFG_SOFT, {16'($urandom), settings[phase].soft_len});
        if (phase == 2) write_reg(CFG_NONE, 32'hFFFF_FFFF);
      end
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      axis_pairs();
      for (n = 0; n < 88; n++) begin
        // one hold-off until the pipe has emptied
        if (phase == 3 && n == 40) drain();
        // quiet stretch inside a phase with idling or stalls
        if (n == 60 && phase % 4 != 0) begin
          idle_pct = 0;
          stall_pct = 0;
        end
        send_pair(rand_pair());
      end
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sgpa_pkg.sv
rtl/softened_gravity_pair_accel.sv
sim/sgpa_checker.sv
sim/softened_gravity_pair_accel_test.sv
